// ===== rtl/srde_pkg.sv =====
// types and constants shared by the sound register delta encoder
`timescale 1ns / 1ps
`default_nettype none

package srde_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_ENCODE = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    // byte codes and tag bits
    localparam logic [7:0] BYTE_STOP  = 8'h00;
    localparam logic [7:0] PAUSE_ONE  = 8'h01;
    localparam logic [1:0] TAG_FREQ   = 2'b11;
    localparam logic [2:0] TAG_CTRL   = 3'b101;
    localparam logic [2:0] TAG_VOL    = 3'b001;
    localparam logic [1:0] TAG_FULL   = 2'b10;
    localparam logic [2:0] TAG_SUST   = 3'b100;
    localparam logic [2:0] TAG_PAUSE  = 3'b000;

    // frame counts
    localparam logic [6:0] RUN_MAX    = 7'd32;
    localparam logic [4:0] RUN_D_MAX  = 5'd31;
    localparam logic [6:0] PAIR_MAX   = 7'd2;

    // kind of byte the datapath forms
    typedef enum logic [2:0] {
        SEL_PAUSE,
        SEL_DELTA,
        SEL_FULL_HI,
        SEL_FULL_LO,
        SEL_SUSTAIN,
        SEL_STOP
    } t_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_FULL_LO,
        ST_SUSTAIN,
        ST_STOP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_ref;
        logic emit;
        t_sel sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_sel head;
        logic last_next;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/srde_if.sv =====
// stream interfaces for interval items and code bytes
`timescale 1ns / 1ps
`default_nettype none

interface srde_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] control;
    logic [4:0] frequency;
    logic [3:0] volume;
    logic [6:0] duration;

    modport source (output valid, operation, control, frequency, volume, duration,
                    input ready);
    modport sink   (input valid, operation, control, frequency, volume, duration,
                    output ready);
endinterface

interface srde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_of_run;

    modport source (output valid, code_byte, last_of_run, input ready);
    modport sink   (input valid, code_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/srde_ctrl.sv =====
// controller state machine sequencing the code bytes of one item
`timescale 1ns / 1ps
`default_nettype none

module srde_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [1:0]      i_in_op,
    input  srde_pkg::t_status    i_status,
    output logic                 o_in_ready,
    output srde_pkg::t_cmd       o_cmd
);

    srde_pkg::t_state r_state;
    srde_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srde_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.load_ref = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.sel      = srde_pkg::SEL_SUSTAIN;
        unique case (r_state)
            srde_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    priority if (i_in_op == srde_pkg::OP_ENCODE) begin
                        o_cmd.capture = 1'b1;
                        n_state       = srde_pkg::ST_HEAD;
                    end else if (i_in_op == srde_pkg::OP_LOAD) begin
                        o_cmd.load_ref = 1'b1;
                    end else if (i_in_op == srde_pkg::OP_END) begin
                        n_state = srde_pkg::ST_STOP;
                    end else begin
                        n_state = srde_pkg::ST_IDLE;
                    end
                end
            end
            srde_pkg::ST_HEAD: begin
                o_cmd.sel  = i_status.head;
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) begin
                    priority if (i_status.head == srde_pkg::SEL_FULL_HI) begin
                        n_state = srde_pkg::ST_FULL_LO;
                    end else if (i_status.last_next) begin
                        n_state = srde_pkg::ST_IDLE;
                    end else begin
                        n_state = srde_pkg::ST_SUSTAIN;
                    end
                end
            end
            srde_pkg::ST_FULL_LO: begin
                o_cmd.sel  = srde_pkg::SEL_FULL_LO;
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = i_status.last_next ? srde_pkg::ST_IDLE : srde_pkg::ST_SUSTAIN;
                end
            end
            srde_pkg::ST_SUSTAIN: begin
                o_cmd.sel  = srde_pkg::SEL_SUSTAIN;
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.last_next) begin
                    n_state = srde_pkg::ST_IDLE;
                end
            end
            srde_pkg::ST_STOP: begin
                o_cmd.sel  = srde_pkg::SEL_STOP;
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = srde_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srde_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/srde_dp.sv =====
// datapath: reference registers, frame counter, byte former, output register
`timescale 1ns / 1ps
`default_nettype none

module srde_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_data,
    input  wire logic [3:0]    i_control,
    input  wire logic [4:0]    i_frequency,
    input  wire logic [3:0]    i_volume,
    input  wire logic [6:0]    i_duration,
    input  srde_pkg::t_cmd     i_cmd,
    input  wire logic          i_out_ready,
    output srde_pkg::t_status  o_status,
    output logic               o_out_valid,
    output logic [7:0]         o_code_byte,
    output logic               o_last_of_run
);

    logic                r_mode;
    logic [3:0]          r_ref_ctl;
    logic [4:0]          r_ref_frq;
    logic [3:0]          r_ref_vol;
    logic [3:0]          r_ctl;
    logic [4:0]          r_frq;
    logic [3:0]          r_vol;
    logic [6:0]          r_frames;
    logic                r_fc;
    logic                r_cc;
    srde_pkg::t_sel      r_head;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic                cc;
    logic                fc;
    logic                vc;
    logic [1:0]          n_changes;
    srde_pkg::t_sel      n_head;
    logic [6:0]          n_frames_in;

    logic                long_run;
    logic [6:0]          run_sub;
    logic [4:0]          run_d;
    logic [6:0]          run_rem;
    logic                pair;
    logic                pair_d;
    logic [6:0]          pair_rem;
    logic [7:0]          n_byte;
    logic [6:0]          n_rem;
    logic                n_last;

    // change detection against the reference at capture
    assign cc        = (i_control != r_ref_ctl);
    assign fc        = (i_frequency != r_ref_frq);
    assign vc        = (i_volume != r_ref_vol);
    assign n_changes = {1'b0, cc} + {1'b0, fc} + {1'b0, vc};
    assign n_frames_in = (i_duration == 7'd0) ? 7'd1 : i_duration;

    always_comb begin
        priority if ((i_volume == 4'd0) && (n_changes != 2'd0)) begin
            n_head = srde_pkg::SEL_PAUSE;
        end else if (n_changes == 2'd1) begin
            n_head = srde_pkg::SEL_DELTA;
        end else if (n_changes != 2'd0) begin
            n_head = srde_pkg::SEL_FULL_HI;
        end else begin
            n_head = srde_pkg::SEL_SUSTAIN;
        end
    end

    // frame splitting: runs of up to 32, or pairs for register writes
    assign long_run = (r_frames > srde_pkg::RUN_MAX);
    assign run_sub  = r_frames - 7'd1;
    assign run_d    = long_run ? srde_pkg::RUN_D_MAX : run_sub[4:0];
    assign run_rem  = long_run ? (r_frames - srde_pkg::RUN_MAX) : 7'd0;
    assign pair     = (r_frames > srde_pkg::PAIR_MAX);
    // a register write covers two frames whenever at least two are left
    assign pair_d   = (r_frames > 7'd1);
    assign pair_rem = pair ? (r_frames - srde_pkg::PAIR_MAX) : 7'd0;

    always_comb begin
        unique case (i_cmd.sel)
            srde_pkg::SEL_PAUSE: begin
                n_byte = (run_d != 5'd0) ? {run_d, srde_pkg::TAG_PAUSE} : srde_pkg::PAUSE_ONE;
                n_rem  = run_rem;
                n_last = (run_rem == 7'd0);
            end
            srde_pkg::SEL_DELTA: begin
                priority if (r_fc) begin
                    n_byte = {r_frq, pair_d, srde_pkg::TAG_FREQ};
                end else if (r_cc) begin
                    n_byte = {r_ctl, pair_d, srde_pkg::TAG_CTRL};
                end else begin
                    n_byte = {r_vol, pair_d, srde_pkg::TAG_VOL};
                end
                n_rem  = pair_rem;
                n_last = (pair_rem == 7'd0);
            end
            srde_pkg::SEL_FULL_HI: begin
                n_byte = {r_frq, pair_d, srde_pkg::TAG_FULL};
                n_rem  = pair_rem;
                n_last = 1'b0;
            end
            srde_pkg::SEL_FULL_LO: begin
                n_byte = {r_ctl, r_vol};
                n_rem  = r_frames;
                n_last = (r_frames == 7'd0);
            end
            srde_pkg::SEL_SUSTAIN: begin
                n_byte = {run_d, srde_pkg::TAG_SUST};
                n_rem  = run_rem;
                n_last = (run_rem == 7'd0);
            end
            srde_pkg::SEL_STOP: begin
                n_byte = srde_pkg::BYTE_STOP;
                n_rem  = r_frames;
                n_last = 1'b1;
            end
            default: begin
                n_byte = srde_pkg::BYTE_STOP;
                n_rem  = r_frames;
                n_last = 1'b1;
            end
        endcase
    end

    // control state: mode, reference, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_ref_ctl   <= 4'd0;
            r_ref_frq   <= 5'd0;
            r_ref_vol   <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.load_ref
                || (i_cmd.capture && !((r_mode == 1'b0) && (i_volume == 4'd0)))) begin
                r_ref_ctl <= i_control;
                r_ref_frq <= i_frequency;
                r_ref_vol <= i_volume;
            end else if (i_cmd.capture) begin
                r_ref_vol <= 4'd0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ctl    <= i_control;
            r_frq    <= i_frequency;
            r_vol    <= i_volume;
            r_fc     <= fc;
            r_cc     <= cc;
            r_head   <= n_head;
            r_frames <= n_frames_in;
        end else if (i_cmd.emit) begin
            r_frames <= n_rem;
        end
        if (i_cmd.emit) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

    assign o_status.head      = r_head;
    assign o_status.last_next = n_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_code_byte   = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/sound_register_delta_encoder_core.sv =====
// top level of the sound register delta encoder
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------------------
//  i_item   | in  | valid / ready  | operation, control, frequency, volume,
//           |     |                | duration
//  o_code   | out | valid / ready  | code_byte, last_of_run
//  cfg      | in  | i_cfg_we       | i_cfg_data = update_mode
//
//  an item is taken in its transfer cycle; the sequencer then forms its code
//  bytes, n from 0 to 6, one byte per cycle while the output is free, into the
//  single output register
//  items are taken only while the sequencer is idle; the last byte of a run may
//  still wait in the output register while the next item is transferred
//  a stall on the output holds the sequencer and the frame counter
//  synchronous active-low reset clears the reference setting, the mode and the
//  output valid
`timescale 1ns / 1ps
`default_nettype none

module sound_register_delta_encoder_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_data,
    srde_in_if.sink       i_item,
    srde_out_if.source    o_code
);

    srde_pkg::t_cmd    cmd;
    srde_pkg::t_status status;
    logic              in_ready;

    // sequencer: decides which byte kind goes out each cycle
    srde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_op    (i_item.operation),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_item.ready = in_ready;

    // datapath: reference compare, frame splitting, output register
    srde_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_control     (i_item.control),
        .i_frequency   (i_item.frequency),
        .i_volume      (i_item.volume),
        .i_duration    (i_item.duration),
        .i_cmd         (cmd),
        .i_out_ready   (o_code.ready),
        .o_status      (status),
        .o_out_valid   (o_code.valid),
        .o_code_byte   (o_code.code_byte),
        .o_last_of_run (o_code.last_of_run)
    );

endmodule

`default_nettype wire

// ===== verif/srde_checker.sv =====
// transfer monitor, code byte predictor and scoreboard for the delta encoder
`timescale 1ns / 1ps

module srde_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    srde_in_if   item_mon,
    srde_out_if  code_mon,
    output int   fail_count,
    output int   n_expected
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_code;

    t_code      code_q[$];
    logic [3:0] ref_ctrl;
    logic [4:0] ref_freq;
    logic [3:0] ref_vol;
    logic       update_mode_r;

    initial begin
        fail_count = 0;
        n_expected = 0;
    end

    function automatic void push_code(input logic [7:0] b);
        t_code e;
        e.code = b;
        e.last = 1'b0;
        code_q = {code_q, e};
    endfunction

    // takes up to cap frames off the count, returns frames covered minus one
    function automatic logic [4:0] take_frames(inout int unsigned frames,
                                               input int unsigned cap);
        logic [4:0] d;
        if (frames > cap) begin
            d = 5'(cap - 1);
            frames = frames - cap;
        end else begin
            d = 5'(frames - 1);
            frames = 0;
        end
        return d;
    endfunction

    task automatic predict_codes(input logic [1:0] op, input logic [3:0] c,
                                 input logic [4:0] f, input logic [3:0] v,
                                 input logic [6:0] dur);
        int unsigned frames;
        int unsigned n_chg;
        bit          chg_c, chg_f, chg_v;
        logic [4:0]  d;
        t_code       tail;
        case (op)
            srde_pkg::OP_LOAD: begin
                ref_ctrl = c;
                ref_freq = f;
                ref_vol  = v;
            end
            srde_pkg::OP_END: begin
                tail.code = srde_pkg::BYTE_STOP;
                tail.last = 1'b1;
                code_q = {code_q, tail};
            end
            srde_pkg::OP_ENCODE: begin
                frames = (dur == 0) ? 1 : dur;
                chg_c  = (c != ref_ctrl);
                chg_f  = (f != ref_freq);
                chg_v  = (v != ref_vol);
                n_chg  = chg_c + chg_f + chg_v;
                if (v == 0 && n_chg != 0) begin
                    d = take_frames(frames, srde_pkg::RUN_MAX);
                    push_code((d != 0) ? {d, srde_pkg::TAG_PAUSE} : srde_pkg::PAUSE_ONE);
                end else if (n_chg == 1) begin
                    d = take_frames(frames, srde_pkg::PAIR_MAX);
                    if (chg_f)
                        push_code({f, d[0], srde_pkg::TAG_FREQ});
                    else if (chg_c)
                        push_code({c, d[0], srde_pkg::TAG_CTRL});
                    else
                        push_code({v, d[0], srde_pkg::TAG_VOL});
                end else if (n_chg > 1) begin
                    d = take_frames(frames, srde_pkg::PAIR_MAX);
                    push_code({f, d[0], srde_pkg::TAG_FULL});
                    push_code({c, v});
                end
                while (frames > 0) begin
                    d = take_frames(frames, srde_pkg::RUN_MAX);
                    push_code({d, srde_pkg::TAG_SUST});
                end
                if (!update_mode_r && v == 0) begin
                    ref_vol = 4'd0;
                end else begin
                    ref_ctrl = c;
                    ref_freq = f;
                    ref_vol  = v;
                end
                code_q[code_q.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_code want;
        if (!i_rst_n) begin
            ref_ctrl      = 4'd0;
            ref_freq      = 5'd0;
            ref_vol       = 4'd0;
            update_mode_r = 1'b0;
            code_q.delete();
        end else begin
            if (i_cfg_we)
                update_mode_r = i_cfg_data;
            if (code_mon.valid && code_mon.ready) begin
                if (code_q.size() == 0) begin
                    $error("unexpected code byte %02h last_of_run %0b",
                           code_mon.code_byte, code_mon.last_of_run);
                    fail_count++;
                end else begin
                    want = code_q.pop_front();
                    if (code_mon.code_byte !== want.code) begin
                        $error("code_byte expected %02h actual %02h",
                               want.code, code_mon.code_byte);
                        fail_count++;
                    end
                    if (code_mon.last_of_run !== want.last) begin
                        $error("last_of_run expected %0b actual %0b",
                               want.last, code_mon.last_of_run);
                        fail_count++;
                    end
                end
            end
            if (item_mon.valid && item_mon.ready)
                predict_codes(item_mon.operation, item_mon.control, item_mon.frequency,
                              item_mon.volume, item_mon.duration);
        end
        n_expected = code_q.size();
    end

endmodule

// ===== verif/tb.sv =====
// stimulus and verdict for the sound register delta encoder core
`timescale 1ns / 1ps

module tb;

    // the one operation code the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // idle cycles before a mode write, longer than one item with six bytes
    localparam int SETTLE_CYCLES = 12;
    // length of the long output hold-off
    localparam int HOLD_CYCLES = 60;
    // random items per idling phase, ignored codes not counted
    localparam int PHASE_ITEMS = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    srde_in_if  item_ch ();
    srde_out_if code_ch ();

    int fail_count;
    int n_expected;

    // percentages that shape idling on either side
    int idle_pct  = 0;
    int stall_pct = 0;

    // long hold-off on the output, asked by stimulus, counted by the receiver
    bit hold_req  = 1'b0;
    int hold_left = 0;

    // last setting sent, so random items mostly differ in few registers
    logic [3:0] last_c = 4'd0;
    logic [4:0] last_f = 5'd0;
    logic [3:0] last_v = 4'd0;

    sound_register_delta_encoder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_ch),
        .o_code     (code_ch)
    );

    srde_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .item_mon   (item_ch),
        .code_mon   (code_ch),
        .fail_count (fail_count),
        .n_expected (n_expected)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            code_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            code_ch.ready <= 1'b0;
        end else begin
            code_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one item after a random gap and wait for its transfer;
    // valid stays high when the next call offers at once
    task automatic send_item(input logic [1:0] op, input logic [3:0] c,
                             input logic [4:0] f, input logic [3:0] v,
                             input logic [6:0] dur);
        while ($urandom_range(99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.control   <= c;
        item_ch.frequency <= f;
        item_ch.volume    <= v;
        item_ch.duration  <= dur;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        last_c = c;
        last_f = f;
        last_v = v;
    endtask

    // random item, mostly encodes that change zero to three registers
    task automatic send_random(output bit counted);
        int         pick;
        logic [1:0] op;
        logic [3:0] c, v;
        logic [4:0] f;
        logic [6:0] dur;
        pick = $urandom_range(99);
        if (pick < 74)
            op = srde_pkg::OP_ENCODE;
        else if (pick < 84)
            op = srde_pkg::OP_LOAD;
        else if (pick < 93)
            op = srde_pkg::OP_END;
        else
            op = OP_UNUSED;
        c = ($urandom_range(99) < 30) ? $urandom_range(15) : last_c;
        f = ($urandom_range(99) < 30) ? $urandom_range(31) : last_f;
        pick = $urandom_range(9);
        if (pick < 2)
            v = 4'd0;
        else if (pick < 5)
            v = $urandom_range(15);
        else
            v = last_v;
        // short intervals dominate, long ones reach the sustain chains
        pick = $urandom_range(99);
        if (pick < 55)
            dur = $urandom_range(3);
        else if (pick < 85)
            dur = $urandom_range(40);
        else
            dur = $urandom_range(127);
        send_item(op, c, f, v, dur);
        counted = (op != OP_UNUSED);
    endtask

    // let every expected byte out, then give an item with no bytes time to finish
    task automatic drain_codes();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (n_expected == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode write only while the block is idle
    task automatic set_mode(input logic mode);
        drain_codes();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int ph;
        int n_sent;
        bit counted;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.operation <= srde_pkg::OP_ENCODE;
        item_ch.control   <= 4'd0;
        item_ch.frequency <= 5'd0;
        item_ch.volume    <= 4'd0;
        item_ch.duration  <= 7'd0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, mode 0 from reset, reference all zero
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd0, 4'd0, 7'd0);     // zero duration, no change
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd0, 4'd15, 7'd1);    // volume delta, one frame
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd0, 4'd9, 7'd2);     // volume delta, two frames
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd31, 4'd9, 7'd127);  // frequency delta, long
        send_item(srde_pkg::OP_ENCODE, 4'd15, 5'd31, 4'd9, 7'd3);   // control delta, short
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd0, 4'd9, 7'd127);   // full write, six bytes
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd0, 4'd0, 7'd127);   // silence with change
        send_item(srde_pkg::OP_LOAD, 4'd5, 5'd10, 4'd7, 7'd0);
        send_item(srde_pkg::OP_ENCODE, 4'd5, 5'd10, 4'd0, 7'd1);    // one-frame pause
        send_item(srde_pkg::OP_ENCODE, 4'd5, 5'd10, 4'd0, 7'd33);   // silence without change
        send_item(srde_pkg::OP_ENCODE, 4'd5, 5'd10, 4'd3, 7'd32);
        send_item(srde_pkg::OP_ENCODE, 4'd9, 5'd20, 4'd0, 7'd32);   // pause of exactly 32
        send_item(srde_pkg::OP_LOAD, 4'd15, 5'd31, 4'd15, 7'd127);
        send_item(srde_pkg::OP_ENCODE, 4'd0, 5'd0, 4'd0, 7'd0);     // pause, zero duration
        send_item(srde_pkg::OP_END, 4'd15, 5'd31, 4'd15, 7'd127);
        send_item(OP_UNUSED, 4'd15, 5'd31, 4'd15, 7'd127);
        send_item(srde_pkg::OP_ENCODE, 4'd3, 5'd0, 4'd0, 7'd33);    // pause, one sustain
        send_item(srde_pkg::OP_LOAD, 4'd0, 5'd0, 4'd0, 7'd0);
        send_item(srde_pkg::OP_ENCODE, 4'd15, 5'd31, 4'd15, 7'd2);  // all three change

        // mode 1: silence replaces the whole reference
        set_mode(1'b1);
        send_item(srde_pkg::OP_LOAD, 4'd3, 5'd4, 4'd5, 7'd0);
        send_item(srde_pkg::OP_ENCODE, 4'd6, 5'd7, 4'd0, 7'd5);
        send_item(srde_pkg::OP_ENCODE, 4'd6, 5'd7, 4'd0, 7'd5);
        send_item(srde_pkg::OP_ENCODE, 4'd6, 5'd7, 4'd1, 7'd1);
        send_item(srde_pkg::OP_END, 4'd0, 5'd0, 4'd0, 7'd0);

        // random part, one idling pattern and one mode per phase
        for (ph = 0; ph < 4; ph++) begin
            set_mode(ph[0]);
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 73;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 73;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            n_sent = 0;
            while (n_sent < PHASE_ITEMS) begin
                // long output hold-off while items keep coming, so the input backs up
                if (n_sent == 20 && (ph == 0 || ph == 3))
                    hold_req = 1'b1;
                send_random(counted);
                if (counted)
                    n_sent++;
            end
        end

        drain_codes();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit, several times the slowest correct run
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srde_pkg.sv
rtl/srde_if.sv
rtl/srde_ctrl.sv
rtl/srde_dp.sv
rtl/sound_register_delta_encoder_core.sv
verif/srde_checker.sv
verif/tb.sv
